FILE: rtl/deadline_callback_queue_macros.svh
// Assertion macros shared by the queue modules.
// They expect clk_i and rst_ni in the scope of use.
`ifndef DEADLINE_CALLBACK_QUEUE_MACROS_SVH
`define DEADLINE_CALLBACK_QUEUE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DCQ_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deadline callback queue: assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define DCQ_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deadline callback queue: assertion failed");

`endif

FILE: rtl/dcq_pkg.sv
package dcq_pkg;

  localparam int unsigned CAPACITY = 128;
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);
  localparam int unsigned IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  localparam int unsigned MODE_W    = 2;
  localparam int unsigned NOW_W     = 62;
  localparam int unsigned HANDLE_W  = 32;
  localparam int unsigned DELAY_W   = 32;
  localparam int unsigned FT_W      = 63;
  localparam int unsigned PEND_W    = 8;
  localparam int unsigned MS_W      = 20;
  localparam int unsigned NS_PER_MS = 1000000;

  localparam logic [MODE_W-1:0] MODE_POST  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_POP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [MODE_W-1:0]   mode;
    logic [NOW_W-1:0]    now_time;
    logic [HANDLE_W-1:0] handle;
    logic [DELAY_W-1:0]  post_delay;
    logic [NOW_W-1:0]    limit_time;
  } dcq_in_t;

  typedef struct packed {
    logic                accepted;
    logic                dropped;
    logic                fired;
    logic [HANDLE_W-1:0] out_handle;
    logic [FT_W-1:0]     out_fire_time;
    logic [FT_W-1:0]     wait_time;
    logic [PEND_W-1:0]   pending;
  } dcq_out_t;

endpackage

FILE: rtl/dcq_fire_calc.sv
`include "deadline_callback_queue_macros.svh"

module dcq_fire_calc (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [dcq_pkg::DELAY_W-1:0] delay_i,
  input  logic [dcq_pkg::NOW_W-1:0]   now_i,
  output logic                        done_o,
  output logic [dcq_pkg::FT_W-1:0]    fire_o
);
  import dcq_pkg::*;

  localparam int unsigned ACC_W  = DELAY_W + MS_W;
  localparam int unsigned STEP_W = $clog2(DELAY_W + 1);
  localparam logic [ACC_W-1:0]  NsPerMs  = ACC_W'(NS_PER_MS);
  localparam logic [STEP_W-1:0] LastStep = STEP_W'(DELAY_W);

  logic               busy_q;
  logic               done_q;
  logic [STEP_W-1:0]  step_q;
  logic [DELAY_W-1:0] delay_sr_q;
  logic [ACC_W-1:0]   acc_q;
  logic [ACC_W-1:0]   acc_d;
  logic [FT_W-1:0]    fire_q;
  logic               last_step;

  // The delay is consumed one bit per cycle, most significant bit first.
  assign last_step = (step_q == LastStep);
  assign acc_d     = {acc_q[ACC_W-2:0], 1'b0} + (delay_sr_q[DELAY_W-1] ? NsPerMs : '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        if (last_step) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          step_q <= step_q + STEP_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      delay_sr_q <= delay_i;
      acc_q      <= '0;
    end else if (busy_q && !last_step) begin
      delay_sr_q <= {delay_sr_q[DELAY_W-2:0], 1'b0};
      acc_q      <= acc_d;
    end
    if (busy_q && last_step) begin
      fire_q <= FT_W'(acc_q) + FT_W'(now_i);
    end
  end

  assign done_o = done_q;
  assign fire_o = fire_q;

  `DCQ_ASSERT_NOW(a_start_when_free, start_i, !busy_q)
  `DCQ_ASSERT_NEXT(a_done_after_last, busy_q && last_step && !start_i, done_q)
  `DCQ_ASSERT_NOW(a_done_not_busy, done_q, !busy_q)

endmodule

FILE: rtl/deadline_callback_queue.sv
// Deadline callback queue: an unordered table of pending callbacks.
// The input channel (in_valid_i, in_stall_o, in_data_i) carries one command
// word: post, pop, clear or no operation. Each word gives exactly one result
// word on the output channel (out_valid_o, out_stall_i, out_data_o).
// A post multiplies the delay by one million one bit per cycle, adds the
// current time and stores the entry. A pop reads the table memory one entry
// per cycle to find the earliest fire time; if that time is at or before the
// limit time, the entry is returned and the last entry moves into the freed
// slot. Clear, no operation, an ignored or dropped post and a pop of an empty
// table go straight to the done state.
// One command is in flight at a time; in_stall_o is high while it is worked.
// The result waits in an output register, so the next command is taken
// while an earlier result is still stalled by the receiver; a finished
// result holds the block until the output register is free.
// Reset empties the table at once; no clearing pass is needed.
`include "deadline_callback_queue_macros.svh"

module deadline_callback_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dcq_pkg::dcq_in_t  in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dcq_pkg::dcq_out_t out_data_o
);
  import dcq_pkg::*;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [FT_W-1:0]     fire_time;
  } entry_t;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_SCAN   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_MOVE   = 3'd4;
  localparam logic [2:0] ST_DONE   = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] count_m1;
  logic [CNT_W-1:0] issue_q, issue_d;
  logic             rdv_q, rdv_d;
  logic [IDX_W-1:0] ridx_q, ridx_d;
  entry_t           best_q, best_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  dcq_in_t          in_q;
  dcq_out_t         res_q, res_d;
  dcq_out_t         out_q, out_d;
  logic             out_valid_q;
  logic             in_load;
  logic             out_load;
  logic             out_free;

  entry_t           mem_q [CAPACITY];
  entry_t           rdata_q;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  logic             fc_start;
  logic             fc_done;
  logic [FT_W-1:0]  fc_fire;

  logic [FT_W-1:0]  now_ext;
  logic [FT_W-1:0]  limit_ext;
  logic [FT_W-1:0]  wait_val;
  logic             due;

  dcq_fire_calc u_fire_calc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (fc_start),
    .delay_i (in_data_i.post_delay),
    .now_i   (in_q.now_time),
    .done_o  (fc_done),
    .fire_o  (fc_fire)
  );

  assign count_m1  = count_q - CNT_W'(1);
  assign now_ext   = FT_W'(in_q.now_time);
  assign limit_ext = FT_W'(in_q.limit_time);
  assign wait_val  = (best_q.fire_time > now_ext) ? (best_q.fire_time - now_ext) : '0;
  assign due       = (best_q.fire_time <= limit_ext);
  assign out_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    res_d         = res_q;
    out_d         = res_q;
    out_d.pending = PEND_W'(count_q);
    issue_d       = issue_q;
    rdv_d         = 1'b0;
    ridx_d        = ridx_q;
    best_d        = best_q;
    best_idx_d    = best_idx_q;
    fc_start      = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = issue_q[IDX_W-1:0];
    wr_en         = 1'b0;
    wr_addr       = count_q[IDX_W-1:0];
    wr_data       = '{handle: in_q.handle, fire_time: fc_fire};
    in_load       = 1'b0;
    out_load      = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          in_load = 1'b1;
          res_d   = '0;
          state_d = ST_DONE;
          unique case (in_data_i.mode)
            MODE_POST: begin
              if (in_data_i.handle == '0) begin
                state_d = ST_DONE;
              end else if (count_q >= CNT_W'(CAPACITY)) begin
                res_d.dropped = 1'b1;
              end else begin
                fc_start = 1'b1;
                state_d  = ST_MUL;
              end
            end
            MODE_POP: begin
              if (count_q != '0) begin
                issue_d = '0;
                state_d = ST_SCAN;
              end
            end
            MODE_CLEAR: begin
              count_d = '0;
            end
            default: begin
              state_d = ST_DONE;
            end
          endcase
        end
      end
      ST_MUL: begin
        if (fc_done) begin
          wr_en          = 1'b1;
          res_d.accepted = 1'b1;
          count_d        = count_q + CNT_W'(1);
          state_d        = ST_DONE;
        end
      end
      ST_SCAN: begin
        if (issue_q < count_q) begin
          rd_en   = 1'b1;
          rd_addr = issue_q[IDX_W-1:0];
          rdv_d   = 1'b1;
          ridx_d  = issue_q[IDX_W-1:0];
          issue_d = issue_q + CNT_W'(1);
        end
        if (rdv_q) begin
          if (ridx_q == '0 || rdata_q.fire_time < best_q.fire_time) begin
            best_d     = rdata_q;
            best_idx_d = ridx_q;
          end
          if (ridx_q == count_m1[IDX_W-1:0]) begin
            state_d = ST_DECIDE;
          end
        end
      end
      ST_DECIDE: begin
        res_d.wait_time = wait_val;
        if (due) begin
          res_d.fired         = 1'b1;
          res_d.out_handle    = best_q.handle;
          res_d.out_fire_time = best_q.fire_time;
          count_d             = count_m1;
          rd_en               = 1'b1;
          rd_addr             = count_m1[IDX_W-1:0];
          state_d             = ST_MOVE;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_MOVE: begin
        wr_en   = 1'b1;
        wr_addr = best_idx_q;
        wr_data = rdata_q;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      issue_q     <= '0;
      rdv_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      issue_q <= issue_d;
      rdv_q   <= rdv_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ridx_q     <= ridx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    if (in_load) begin
      in_q <= in_data_i;
    end
    if (out_load) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DCQ_ASSERT_NOW(a_calc_done_in_mul, fc_done, state_q == ST_MUL)
  `DCQ_ASSERT_NOW(a_scan_idx_in_table, (state_q == ST_SCAN) && rdv_q, CNT_W'(ridx_q) < count_q)
  `DCQ_ASSERT_NEXT(a_post_starts_calc, fc_start, (state_q == ST_MUL) && (count_q < CNT_W'(CAPACITY)))
  `DCQ_ASSERT_NOW(a_count_in_range, state_q == ST_IDLE, count_q <= CNT_W'(CAPACITY))

endmodule
